### rtl/incremental_bounding_sphere_assert.svh
// Assertion macros shared by the sphere block
`ifndef INCREMENTAL_BOUNDING_SPHERE_ASSERT_SVH
`define INCREMENTAL_BOUNDING_SPHERE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define IBS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define IBS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

### rtl/ibs_pkg.sv
package ibs_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadiusW  = 31;
  localparam int unsigned MagW     = 33;
  localparam int unsigned SumW     = 68;
  localparam int unsigned RootW    = 35;
  localparam int unsigned DistW    = 35;
  localparam int unsigned NumW     = 70;
  localparam int unsigned QuotW    = 70;
  localparam int unsigned CntW     = 7;
  localparam logic [RadiusW-1:0] RadiusMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_SQRT,
    ST_NEWR,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic new_radius;
    logic mul_axis;
    logic div_init;
    logic div_step;
    logic upd_axis;
    logic next_axis;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic grow;
    logic sq_last;
    logic sqrt_done;
    logic delta_zero;
    logic div_done;
    logic axis_last;
  } status_t;

endpackage

### rtl/ibs_datapath.sv
module ibs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ibs_pkg::cmd_t                        cmd_i,
  output ibs_pkg::status_t                     status_o,
  input  logic signed [ibs_pkg::CoordW-1:0]    point_x_i,
  input  logic signed [ibs_pkg::CoordW-1:0]    point_y_i,
  input  logic signed [ibs_pkg::CoordW-1:0]    point_z_i,
  input  logic                                 first_point_i,
  output logic signed [ibs_pkg::CoordW-1:0]    center_x_o,
  output logic signed [ibs_pkg::CoordW-1:0]    center_y_o,
  output logic signed [ibs_pkg::CoordW-1:0]    center_z_o,
  output logic        [ibs_pkg::RadiusW-1:0]   sphere_radius_o
);

  logic signed [ibs_pkg::CoordW-1:0] pt_q [3];
  logic                              first_q;
  logic signed [ibs_pkg::CoordW-1:0] ctr_q [3];
  logic [ibs_pkg::RadiusW-1:0]       rad_q;
  logic [ibs_pkg::MagW-1:0]          mag_q [3];
  logic [2:0]                        neg_q;
  logic [1:0]                        axis_q;
  logic [ibs_pkg::SumW-1:0]          sum_q;
  logic [ibs_pkg::RootW-1:0]         root_q;
  logic [ibs_pkg::CntW-1:0]          cnt_q;
  logic [ibs_pkg::RadiusW:0]         delta_q;
  logic [ibs_pkg::NumW-1:0]          num_q;
  logic [ibs_pkg::DistW:0]           rem_q;
  logic [ibs_pkg::QuotW-1:0]         quo_q;

  logic [ibs_pkg::MagW-1:0]     mag_sel;
  logic [2*ibs_pkg::MagW-1:0]   sq;
  logic [2*ibs_pkg::RootW-1:0]  trial_sq;
  logic [ibs_pkg::RootW-1:0]    trial;
  logic [ibs_pkg::DistW:0]      rem_sh;
  logic [ibs_pkg::DistW:0]      dist_ext;
  logic [ibs_pkg::DistW:0]      nr_full;
  logic [ibs_pkg::RadiusW-1:0]  nr_sat;
  logic signed [ibs_pkg::CoordW+ibs_pkg::QuotW:0] ctr_ext;
  logic signed [ibs_pkg::CoordW+ibs_pkg::QuotW:0] quo_ext;
  logic signed [ibs_pkg::CoordW+ibs_pkg::QuotW:0] c_new;
  logic signed [ibs_pkg::CoordW-1:0] c_clamp;
  logic [2*ibs_pkg::RadiusW-1:0] r_sq;

  assign mag_sel  = mag_q[axis_q];
  assign sq       = mag_sel * mag_sel;
  assign trial    = root_q | (ibs_pkg::RootW'(1) << cnt_q[5:0]);
  assign trial_sq = trial * trial;
  assign dist_ext = {1'b0, root_q};
  assign rem_sh   = {rem_q[ibs_pkg::DistW-1:0], num_q[ibs_pkg::NumW-1]};
  assign nr_full  = (dist_ext + (ibs_pkg::DistW+1)'(rad_q)) >> 1;
  assign nr_sat   = (nr_full > (ibs_pkg::DistW+1)'(ibs_pkg::RadiusMax)) ?
                    ibs_pkg::RadiusMax : nr_full[ibs_pkg::RadiusW-1:0];
  assign r_sq     = rad_q * rad_q;
  assign ctr_ext  = (ibs_pkg::CoordW+ibs_pkg::QuotW+1)'(ctr_q[axis_q]);
  assign quo_ext  = (ibs_pkg::CoordW+ibs_pkg::QuotW+1)'({1'b0, quo_q});
  assign c_new    = neg_q[axis_q] ? ctr_ext - quo_ext : ctr_ext + quo_ext;
  always_comb begin
    if (c_new > (ibs_pkg::CoordW+ibs_pkg::QuotW+1)'(32'sh7FFFFFFF)) begin
      c_clamp = 32'sh7FFFFFFF;
    end else if (c_new < -(ibs_pkg::CoordW+ibs_pkg::QuotW+1)'(64'sh80000000)) begin
      c_clamp = 32'sh80000000;
    end else begin
      c_clamp = c_new[ibs_pkg::CoordW-1:0];
    end
  end

  assign status_o.first      = first_q;
  assign status_o.grow       = sum_q > ibs_pkg::SumW'(r_sq);
  assign status_o.sq_last    = axis_q == 2'd2;
  assign status_o.sqrt_done  = cnt_q == '0;
  assign status_o.delta_zero = delta_q == '0;
  assign status_o.div_done   = cnt_q == '0;
  assign status_o.axis_last  = axis_q == 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      rad_q    <= '0;
      axis_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        axis_q <= '0;
      end
      if (cmd_i.diff && first_q) begin
        ctr_q[0] <= pt_q[0];
        ctr_q[1] <= pt_q[1];
        ctr_q[2] <= pt_q[2];
        rad_q    <= '0;
      end
      if (cmd_i.square || cmd_i.next_axis) begin
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      if (cmd_i.sqrt_init) begin
        cnt_q <= ibs_pkg::CntW'(ibs_pkg::RootW - 1);
      end
      if (cmd_i.sqrt_step && cnt_q != '0) begin
        cnt_q <= cnt_q - ibs_pkg::CntW'(1);
      end
      if (cmd_i.new_radius) begin
        rad_q <= nr_sat;
      end
      if (cmd_i.div_init) begin
        cnt_q <= ibs_pkg::CntW'(ibs_pkg::NumW);
      end
      if (cmd_i.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - ibs_pkg::CntW'(1);
      end
      if (cmd_i.upd_axis) begin
        ctr_q[axis_q] <= c_clamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
      first_q <= first_point_i;
      sum_q   <= '0;
    end
    if (cmd_i.diff) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [ibs_pkg::MagW-1:0] d;
        d = ibs_pkg::MagW'(pt_q[i]) - ibs_pkg::MagW'(ctr_q[i]);
        neg_q[i] <= d[ibs_pkg::MagW-1];
        mag_q[i] <= d[ibs_pkg::MagW-1] ? -d : d;
      end
    end
    if (cmd_i.square) begin
      sum_q <= sum_q + ibs_pkg::SumW'(sq);
    end
    if (cmd_i.sqrt_init) begin
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if (ibs_pkg::SumW'(trial_sq) <= sum_q && trial_sq[2*ibs_pkg::RootW-1:ibs_pkg::SumW] == '0)
      begin
        root_q <= trial;
      end
    end
    if (cmd_i.new_radius) begin
      delta_q <= (ibs_pkg::RadiusW+1)'(nr_sat) - (ibs_pkg::RadiusW+1)'(rad_q);
    end
    if (cmd_i.mul_axis) begin
      num_q <= ibs_pkg::NumW'(mag_sel * delta_q) + ibs_pkg::NumW'(root_q >> 1);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step && cnt_q != '0) begin
      num_q <= num_q << 1;
      if (rem_sh >= dist_ext) begin
        rem_q <= rem_sh - dist_ext;
        quo_q <= {quo_q[ibs_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[ibs_pkg::QuotW-2:0], 1'b0};
      end
    end
  end

  assign center_x_o      = ctr_q[0];
  assign center_y_o      = ctr_q[1];
  assign center_z_o      = ctr_q[2];
  assign sphere_radius_o = rad_q;

endmodule

### rtl/ibs_ctrl.sv
`include "incremental_bounding_sphere_assert.svh"

module ibs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ibs_pkg::cmd_t    cmd_o,
  input  ibs_pkg::status_t status_i
);

  ibs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibs_pkg::ST_IDLE: if (in_valid_i) state_d = ibs_pkg::ST_DIFF;
      ibs_pkg::ST_DIFF: begin
        state_d = status_i.first ? ibs_pkg::ST_OUT : ibs_pkg::ST_SQ;
      end
      ibs_pkg::ST_SQ: if (status_i.sq_last) state_d = ibs_pkg::ST_CMP;
      ibs_pkg::ST_CMP: state_d = status_i.grow ? ibs_pkg::ST_SQRT : ibs_pkg::ST_OUT;
      ibs_pkg::ST_SQRT: if (status_i.sqrt_done) state_d = ibs_pkg::ST_NEWR;
      ibs_pkg::ST_NEWR: state_d = ibs_pkg::ST_MUL;
      ibs_pkg::ST_MUL: begin
        state_d = status_i.delta_zero ? ibs_pkg::ST_OUT : ibs_pkg::ST_DIV;
      end
      ibs_pkg::ST_DIV: if (status_i.div_done) state_d = ibs_pkg::ST_UPD;
      ibs_pkg::ST_UPD: begin
        state_d = status_i.axis_last ? ibs_pkg::ST_OUT : ibs_pkg::ST_MUL;
      end
      ibs_pkg::ST_OUT: if (out_ready_i) state_d = ibs_pkg::ST_IDLE;
      default: state_d = ibs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ibs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ibs_pkg::ST_DIFF: cmd_o.diff = 1'b1;
      ibs_pkg::ST_SQ:   cmd_o.square = 1'b1;
      ibs_pkg::ST_CMP:  cmd_o.sqrt_init = status_i.grow;
      ibs_pkg::ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ibs_pkg::ST_NEWR: cmd_o.new_radius = 1'b1;
      ibs_pkg::ST_MUL: begin
        cmd_o.mul_axis = 1'b1;
        cmd_o.div_init = 1'b1;
      end
      ibs_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      ibs_pkg::ST_UPD: begin
        cmd_o.upd_axis  = 1'b1;
        cmd_o.next_axis = 1'b1;
      end
      ibs_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  `IBS_ASSERT_IMP(a_hs_excl, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `IBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `IBS_ASSERT_NEXT(a_take, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ibs_pkg::ST_DIFF)

endmodule

### rtl/incremental_bounding_sphere.sv
// Running bounding sphere over Q16.16 points. One point in, one sphere out per beat.
// From the input beat to the ready for the next point: a first point passes the
// difference and output states, a point inside the sphere also squares each axis and
// compares with the radius, and a growing point adds a 35-step bit-serial square root,
// a new radius and, unless it is unchanged, three 70-step restoring divisions of the
// centre move, one per axis, in one shared datapath. A stalled result beat delays the ready.
module incremental_bounding_sphere (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ibs_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [ibs_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [ibs_pkg::CoordW-1:0]  point_z_i,
  input  logic                               first_point_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ibs_pkg::CoordW-1:0]  center_x_o,
  output logic signed [ibs_pkg::CoordW-1:0]  center_y_o,
  output logic signed [ibs_pkg::CoordW-1:0]  center_z_o,
  output logic        [ibs_pkg::RadiusW-1:0] sphere_radius_o
);

  ibs_pkg::cmd_t    cmd;
  ibs_pkg::status_t status;

  ibs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ibs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .first_point_i   (first_point_i),
    .center_x_o      (center_x_o),
    .center_y_o      (center_y_o),
    .center_z_o      (center_z_o),
    .sphere_radius_o (sphere_radius_o)
  );

endmodule
